### src/utf8sv_pkg.sv
// status codes and shared types for the utf-8 stream validator
package utf8sv_pkg;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_OK        = 3'd0;
   localparam status_type STATUS_BAD_HDR   = 3'd1;
   localparam status_type STATUS_TRUNCATED = 3'd2;
   localparam status_type STATUS_MISS_CONT = 3'd3;
   localparam status_type STATUS_OVERLONG  = 3'd4;

   localparam int ACC_WIDTH = 21;
   typedef logic [ACC_WIDTH-1:0] acc_type;

   // tag bits of a continuation byte 10xxxxxx
   localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

### src/utf8_stream_validator.sv
// utf-8 validator over a byte stream, one byte per clock, one result per buffer
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_data_byte[7:0], req_final_byte
//   rsp      out  rsp_valid/rsp_ready  rsp_status[2:0], rsp_char_count[31:0],
//                                      rsp_error_char_offset[31:0],
//                                      rsp_error_byte_offset[31:0]
//
// one byte is taken per clock; the decode state updates in the same cycle it is taken
// the result of a buffer is captured into the rsp register when its final byte is taken
// req_ready is low only while a result waits and rsp_ready is low
// reset is synchronous and clears the decode state and the result valid
module utf8_stream_validator
   import utf8sv_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_char_count,
   output logic [31:0] rsp_error_char_offset,
   output logic [31:0] rsp_error_byte_offset
);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // decode state
   logic [1:0] bytes_left_ff,   bytes_left_in;
   logic [2:0] seq_len_ff,      seq_len_in;
   acc_type    acc_ff,          acc_in;
   count_type  chars_ff,        chars_in;
   count_type  byte_idx_ff,     byte_idx_in;
   count_type  seq_start_ff,    seq_start_in;
   logic       bad_cont_ff,     bad_cont_in;
   count_type  bad_idx_ff,      bad_idx_in;
   status_type err_ff,          err_in;
   count_type  err_at_ff,       err_at_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff;
   logic [31:0] char_count_ff;
   logic [31:0] char_off_ff;
   logic [31:0] byte_off_ff;

   logic       req_xfer;
   logic       last_xfer;
   logic [7:0] b;
   logic       overlong;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_xfer  = req_valid & req_ready;
   assign last_xfer = req_xfer & req_final_byte;
   assign b         = req_data_byte;

   // per-byte decode step, before the end-of-buffer check
   always_comb begin
      bytes_left_in = bytes_left_ff;
      seq_len_in    = seq_len_ff;
      acc_in        = acc_ff;
      chars_in      = chars_ff;
      seq_start_in  = seq_start_ff;
      bad_cont_in   = bad_cont_ff;
      bad_idx_in    = bad_idx_ff;
      err_in        = err_ff;
      err_at_in     = err_at_ff;
      overlong      = 1'b0;
      if (err_ff == STATUS_OK) begin
         if (bytes_left_ff == 2'd0) begin
            if (b[7] == 1'b0) begin
               chars_in = chars_ff + COUNT_WIDTH'(1);
            end else begin
               seq_start_in = byte_idx_ff;
               bad_cont_in  = 1'b0;
               priority if (b[7:5] == 3'b110) begin
                  seq_len_in    = 3'd2;
                  acc_in        = ACC_WIDTH'(b[4:0]);
                  bytes_left_in = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  seq_len_in    = 3'd3;
                  acc_in        = ACC_WIDTH'(b[3:0]);
                  bytes_left_in = 2'd2;
               end else if (b[7:3] == 5'b11110) begin
                  seq_len_in    = 3'd4;
                  acc_in        = ACC_WIDTH'(b[2:0]);
                  bytes_left_in = 2'd3;
               end else begin
                  err_in    = STATUS_BAD_HDR;
                  err_at_in = byte_idx_ff;
               end
            end
         end else begin
            if (!bad_cont_ff) begin
               if (b[7:6] != CONT_TAG) begin
                  bad_cont_in = 1'b1;
                  bad_idx_in  = byte_idx_ff - COUNT_WIDTH'(1);
               end else begin
                  acc_in = {acc_ff[ACC_WIDTH-7:0], b[5:0]};
               end
            end
            bytes_left_in = bytes_left_ff - 2'd1;
            if (bytes_left_in == 2'd0) begin
               overlong = (seq_len_ff == 3'd2 && acc_in < ACC_WIDTH'(24'h80))
                        | (seq_len_ff == 3'd3 && acc_in < ACC_WIDTH'(24'h800))
                        | (seq_len_ff == 3'd4 && acc_in < ACC_WIDTH'(24'h10000));
               priority if (bad_cont_in) begin
                  err_in    = STATUS_MISS_CONT;
                  err_at_in = bad_idx_in;
               end else if (overlong) begin
                  err_in    = STATUS_OVERLONG;
                  err_at_in = byte_idx_ff;
               end else begin
                  chars_in = chars_ff + COUNT_WIDTH'(1);
               end
            end
         end
      end
      // buffer ends inside an open sequence
      if (req_final_byte && err_in == STATUS_OK && bytes_left_in != 2'd0) begin
         err_in    = STATUS_TRUNCATED;
         err_at_in = byte_idx_ff;
      end
      byte_idx_in = byte_idx_ff + COUNT_WIDTH'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (last_xfer) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || last_xfer) begin
         bytes_left_ff <= '0;
         seq_len_ff    <= '0;
         acc_ff        <= '0;
         chars_ff      <= '0;
         byte_idx_ff   <= '0;
         seq_start_ff  <= '0;
         bad_cont_ff   <= 1'b0;
         bad_idx_ff    <= '0;
         err_ff        <= STATUS_OK;
         err_at_ff     <= '0;
      end else if (req_xfer) begin
         bytes_left_ff <= bytes_left_in;
         seq_len_ff    <= seq_len_in;
         acc_ff        <= acc_in;
         chars_ff      <= chars_in;
         byte_idx_ff   <= byte_idx_in;
         seq_start_ff  <= seq_start_in;
         bad_cont_ff   <= bad_cont_in;
         bad_idx_ff    <= bad_idx_in;
         err_ff        <= err_in;
         err_at_ff     <= err_at_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, offsets forced to zero on a clean buffer
   always_ff @(posedge clock) begin
      if (last_xfer) begin
         status_ff     <= err_in;
         char_count_ff <= 32'(chars_in);
         if (err_in != STATUS_OK) begin
            char_off_ff <= 32'(seq_start_in);
            byte_off_ff <= 32'(err_at_in);
         end else begin
            char_off_ff <= '0;
            byte_off_ff <= '0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_char_count        = char_count_ff;
   assign rsp_error_char_offset = char_off_ff;
   assign rsp_error_byte_offset = byte_off_ff;

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      last_xfer |=> rsp_valid)
      else $error("no result after final byte transfer");

   a_ok_has_zero_offsets: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |->
         (rsp_error_char_offset == 32'd0 && rsp_error_byte_offset == 32'd0))
      else $error("ok result carries nonzero offsets");

   a_status_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_OVERLONG))
      else $error("result status out of range");

   a_state_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      last_xfer |=> (byte_idx_ff == '0 && err_ff == STATUS_OK && bytes_left_ff == 2'd0))
      else $error("decode state not cleared after final byte");

endmodule

### sim/testbench.sv
// self-checking testbench for the utf-8 stream validator
module testbench;
   import utf8sv_pkg::*;

   localparam int LIMIT_CYCLES = 100000;
   localparam int RANDOM_BYTES = 420;
   localparam int FULL_RATE_BYTES = 80;

   typedef struct packed {
      status_type  status;
      logic [31:0] chars;
      logic [31:0] char_off;
      logic [31:0] byte_off;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_char_count;
   logic [31:0] rsp_error_char_offset;
   logic [31:0] rsp_error_byte_offset;

   // decoder state kept by the testbench
   logic [1:0]  cont_left;
   logic [2:0]  seq_len;
   acc_type     code_acc;
   logic [31:0] char_total;
   logic [31:0] byte_pos;
   logic [31:0] seq_start;
   logic        bad_cont_seen;
   logic [31:0] bad_cont_pos;
   status_type  err_code;
   logic [31:0] err_pos;

   verdict_type pending_verdicts[$];
   logic [7:0]  frame_bytes[$];
   int          error_count;
   int          bytes_sent;
   int          cycle_count;
   bit          idle_on;

   utf8_stream_validator u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_final_byte        (req_final_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_char_count        (rsp_char_count),
      .rsp_error_char_offset (rsp_error_char_offset),
      .rsp_error_byte_offset (rsp_error_byte_offset)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic clear_decoder();
      cont_left     = '0;
      seq_len       = '0;
      code_acc      = '0;
      char_total    = '0;
      byte_pos      = '0;
      seq_start     = '0;
      bad_cont_seen = 1'b0;
      bad_cont_pos  = '0;
      err_code      = STATUS_OK;
      err_pos       = '0;
   endtask

   // advances the decoder by one byte; queues the verdict on the final byte
   task automatic decode_byte(input logic [7:0] b, input logic fin);
      verdict_type v;
      logic [31:0] pos;
      logic        overlong;
      pos = byte_pos;
      if (err_code == STATUS_OK) begin
         if (cont_left == 0) begin
            if (b < 8'h80) begin
               char_total = char_total + 1;
            end else begin
               seq_start     = pos;
               bad_cont_seen = 1'b0;
               if (b >= 8'hC0 && b <= 8'hDF) begin
                  seq_len  = 3'd2;
                  code_acc = acc_type'(b[4:0]);
               end else if (b >= 8'hE0 && b <= 8'hEF) begin
                  seq_len  = 3'd3;
                  code_acc = acc_type'(b[3:0]);
               end else if (b >= 8'hF0 && b <= 8'hF7) begin
                  seq_len  = 3'd4;
                  code_acc = acc_type'(b[2:0]);
               end else begin
                  err_code = STATUS_BAD_HDR;
                  err_pos  = pos;
               end
               if (err_code == STATUS_OK) cont_left = 2'(seq_len - 3'd1);
            end
         end else begin
            if (!bad_cont_seen) begin
               if (b[7:6] != CONT_TAG) begin
                  bad_cont_seen = 1'b1;
                  bad_cont_pos  = pos - 1;
               end else begin
                  code_acc = {code_acc[ACC_WIDTH-7:0], b[5:0]};
               end
            end
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) begin
               overlong = (seq_len == 3'd2 && code_acc < 21'h80) ||
                          (seq_len == 3'd3 && code_acc < 21'h800) ||
                          (seq_len == 3'd4 && code_acc < 21'h10000);
               if (bad_cont_seen) begin
                  err_code = STATUS_MISS_CONT;
                  err_pos  = bad_cont_pos;
               end else if (overlong) begin
                  err_code = STATUS_OVERLONG;
                  err_pos  = pos;
               end else begin
                  char_total = char_total + 1;
               end
            end
         end
      end
      if (!fin) begin
         byte_pos = pos + 1;
      end else begin
         // truncation wins over a bad continuation inside a cut sequence
         if (err_code == STATUS_OK && cont_left != 0) begin
            err_code = STATUS_TRUNCATED;
            err_pos  = pos;
         end
         v.status   = err_code;
         v.chars    = char_total;
         v.char_off = (err_code != STATUS_OK) ? seq_start : 32'd0;
         v.byte_off = (err_code != STATUS_OK) ? err_pos : 32'd0;
         pending_verdicts.push_back(v);
         clear_decoder();
      end
   endtask

   // entered and left at a falling edge; valid stays high between bytes unless an idle gap is put in
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, fin);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // hold the sender off until every outstanding verdict has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_verdicts.size() != 0);
   endtask

   task automatic append_seq(input int len, input logic [20:0] cp);
      case (len)
         1: frame_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            frame_bytes.push_back({3'b110, cp[10:6]});
            frame_bytes.push_back({CONT_TAG, cp[5:0]});
         end
         3: begin
            frame_bytes.push_back({4'b1110, cp[15:12]});
            frame_bytes.push_back({CONT_TAG, cp[11:6]});
            frame_bytes.push_back({CONT_TAG, cp[5:0]});
         end
         default: begin
            frame_bytes.push_back({5'b11110, cp[20:18]});
            frame_bytes.push_back({CONT_TAG, cp[17:12]});
            frame_bytes.push_back({CONT_TAG, cp[11:6]});
            frame_bytes.push_back({CONT_TAG, cp[5:0]});
         end
      endcase
   endtask

   // mostly well-formed text with occasional damage, plus some pure noise
   task automatic build_random_frame();
      int          len;
      int          flavor;
      int          at;
      logic [20:0] cp;
      logic [7:0]  junk;
      frame_bytes = {};
      len = 1;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            len    = $urandom_range(1, 4);
            flavor = $urandom_range(0, 19);
            case (len)
               1: cp = 21'($urandom_range(0, 'h7F));
               2: cp = 21'($urandom_range('h80, 'h7FF));
               3: cp = 21'($urandom_range('h800, 'hFFFF));
               default: cp = 21'($urandom_range('h10000, 'h1FFFFF));
            endcase
            // overlong: a value that would fit a shorter form
            if (flavor == 0 && len == 2) cp = 21'($urandom_range(0, 'h7F));
            if (flavor == 0 && len == 3) cp = 21'($urandom_range(0, 'h7FF));
            if (flavor == 0 && len == 4) cp = 21'($urandom_range(0, 'hFFFF));
            append_seq(len, cp);
            if (flavor == 1 && len > 1) begin
               at   = frame_bytes.size() - $urandom_range(1, len - 1);
               junk = 8'($urandom);
               if (junk[7:6] == CONT_TAG) junk[7] = $urandom_range(0, 1) ? 1'b1 : 1'b0;
               if (junk[7:6] == CONT_TAG) junk[6] = 1'b1;
               frame_bytes[at] = junk;
            end
            if (flavor == 2) begin
               if ($urandom_range(0, 1))
                  frame_bytes.push_back(8'($urandom_range('h80, 'hBF)));
               else
                  frame_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
            end
            if (flavor == 3) frame_bytes.push_back(8'($urandom));
         end
         // cut the last sequence short now and then
         if (len > 1 && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, len - 1)) void'(frame_bytes.pop_back());
      end
   endtask

   task automatic test_directed_cases();
      // ascii extremes, a surrogate and a value above the unicode range are all fine
      frame_bytes = '{8'h7F, 8'h00, 8'hC2, 8'h80, 8'hED, 8'hA0, 8'h80,
                      8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_frame();
      frame_bytes = '{8'hC0, 8'h80};
      send_frame();
      frame_bytes = '{8'hE0, 8'h9F, 8'hBF};
      send_frame();
      frame_bytes = '{8'hFF};
      send_frame();
      // bytes after an error are ignored
      frame_bytes = '{8'h80, 8'h41};
      send_frame();
      frame_bytes = '{8'h41, 8'hF8};
      send_frame();
      frame_bytes = '{8'hE0, 8'h41, 8'h80};
      send_frame();
      // bad continuation inside a cut sequence reports truncation
      frame_bytes = '{8'hF0, 8'h41};
      send_frame();
      frame_bytes = '{8'hC2};
      send_frame();
   endtask

   task automatic test_random_frames();
      int frames;
      frames = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         // a stretch with no idling in the middle of the run
         idle_on = !(frames >= 30 && frames < 40);
         build_random_frame();
         send_frame();
         frames++;
         if (frames % 15 == 0) wait_for_drain();
      end
   endtask

   task automatic test_full_rate();
      int target;
      target  = bytes_sent + FULL_RATE_BYTES;
      idle_on = 1'b0;
      while (bytes_sent < target) begin
         build_random_frame();
         send_frame();
      end
   endtask

   // result side: random stall bursts while idling is on
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no buffer outstanding: status %0d", rsp_status);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_char_count != want.chars) begin
               $error("char_count: expected %0d, got %0d", want.chars, rsp_char_count);
               error_count++;
            end
            if (rsp_error_char_offset != want.char_off) begin
               $error("error_char_offset: expected %0d, got %0d",
                      want.char_off, rsp_error_char_offset);
               error_count++;
            end
            if (rsp_error_byte_offset != want.byte_off) begin
               $error("error_byte_offset: expected %0d, got %0d",
                      want.byte_off, rsp_error_byte_offset);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'h00;
      req_final_byte = 1'b0;
      error_count    = 0;
      bytes_sent     = 0;
      cycle_count    = 0;
      idle_on        = 1'b1;
      clear_decoder();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_frames();
      test_full_rate();

      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
src/utf8sv_pkg.sv
src/utf8_stream_validator.sv
sim/testbench.sv
